[src/epoch_seconds_to_calendar_defines.svh]
// Assertion macros shared by the checker of the seconds-to-calendar converter.
`ifndef EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ep2cal checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ep2cal checker: next-cycle property failed");

`endif

[src/ep2cal_pkg.sv]
// Package with the constants and tables of the seconds-to-calendar converter.
`timescale 1ns / 1ps
`default_nettype none

package ep2cal_pkg;

    localparam int EPOCH_W  = 32;
    localparam int DAYS_W   = 16;
    localparam int TOD_W    = 17;
    localparam int MINS_W   = 11;
    localparam int YEAR_W   = 12;

    localparam logic [25:0] DAY_RECIP   = 26'd50903317;
    localparam int          DAY_SHIFT   = 35;
    localparam logic [9:0]  DAY_DIV     = 10'd675;

    localparam logic [17:0] MIN_RECIP   = 18'd139811;
    localparam int          MIN_SHIFT   = 23;
    localparam logic [11:0] HOUR_RECIP  = 12'd2185;
    localparam int          HOUR_SHIFT  = 17;
    localparam logic [6:0]  SIXTY       = 7'd60;

    localparam logic [15:0] EPOCH_OFFSET  = 16'd671;
    localparam logic [15:0] SKIP_LEAP_DAY = 16'd47541;
    localparam logic [16:0] CYCLE_RECIP   = 17'd91868;
    localparam int          CYCLE_SHIFT   = 27;
    localparam logic [10:0] CYCLE_DAYS    = 11'd1461;
    localparam logic [10:0] CYCLE_LAST    = 11'd1460;
    localparam logic [11:0] YEAR_RECIP    = 12'd2873;
    localparam int          YEAR_SHIFT    = 20;
    localparam logic [8:0]  YEAR_DAYS     = 9'd365;
    localparam logic [11:0] BASE_YEAR     = 12'd1968;
    localparam logic [3:0]  MARCH_JAN     = 4'd10;

    // First day of each month in a year that starts on the first of March.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] start;
        case (mp)
            4'd0:    start = 9'd0;
            4'd1:    start = 9'd31;
            4'd2:    start = 9'd61;
            4'd3:    start = 9'd92;
            4'd4:    start = 9'd122;
            4'd5:    start = 9'd153;
            4'd6:    start = 9'd184;
            4'd7:    start = 9'd214;
            4'd8:    start = 9'd245;
            4'd9:    start = 9'd275;
            4'd10:   start = 9'd306;
            4'd11:   start = 9'd337;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

endpackage

`default_nettype wire

[src/epoch_seconds_to_calendar.sv]
// Top level of the seconds-to-calendar converter: handshake, day split and time of day.
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    s_epoch_seconds (32 bits)
//  m_        out        m_valid/m_ready    full_year, year_in_century, month, day,
//                                          hour, minute, second
//
// One request enters per cycle unless a stall on the output holds the pipeline.
// The rate is set by the eight-stage pipeline, which advances as a whole.
// A stall on the output freezes every stage; nothing is dropped or repeated.
// Reset is synchronous and clears the stage valid bits only.
`timescale 1ns / 1ps
`default_nettype none

module epoch_seconds_to_calendar (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [ep2cal_pkg::EPOCH_W-1:0]    s_epoch_seconds,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [ep2cal_pkg::YEAR_W-1:0]     m_full_year,
    output logic      [6:0]                        m_year_in_century,
    output logic      [3:0]                        m_month,
    output logic      [4:0]                        m_day,
    output logic      [4:0]                        m_hour,
    output logic      [5:0]                        m_minute,
    output logic      [5:0]                        m_second
);

    logic        adv;
    logic [7:0]  valid_reg, valid_next;

    logic [31:0] s1_reg;
    logic [31:0] s2_reg;
    logic [50:0] prod1_reg, prod1_next;

    logic [15:0] days_reg, days_next;
    logic [16:0] tod_reg, tod_next;
    logic [25:0] days_mul;
    logic [24:0] rem_wide;

    logic [16:0] tod4_reg;
    logic [34:0] prods_reg, prods_next;

    logic [10:0] mins_reg, mins_next;
    logic [5:0]  sec5_reg, sec5_next;
    logic [16:0] mins_mul;

    logic [22:0] prodh_reg, prodh_next;
    logic [10:0] mins6_reg;
    logic [5:0]  sec6_reg;

    logic [4:0]  hour7_reg, hour7_next;
    logic [5:0]  minute7_reg, minute7_next;
    logic [5:0]  sec7_reg;
    logic [10:0] hour_mul;

    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [5:0]  second_reg;

    assign adv     = !valid_reg[7] || m_ready;
    assign s_ready = adv;
    assign m_valid = valid_reg[7];

    always_comb begin
        valid_next = {valid_reg[6:0], s_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= valid_next;
        end
    end

    // Days are the seconds over 128 divided by 675, by reciprocal multiply.
    always_comb begin
        prod1_next = {26'd0, s1_reg[31:7]} * {25'd0, ep2cal_pkg::DAY_RECIP};
    end

    always_comb begin
        days_next = prod1_reg[50:ep2cal_pkg::DAY_SHIFT];
        days_mul  = {10'd0, days_next} * {16'd0, ep2cal_pkg::DAY_DIV};
        rem_wide  = s2_reg[31:7] - days_mul[24:0];
        tod_next  = {rem_wide[9:0], s2_reg[6:0]};
    end

    always_comb begin
        prods_next = {18'd0, tod_reg} * {17'd0, ep2cal_pkg::MIN_RECIP};
    end

    always_comb begin
        mins_next = prods_reg[33:ep2cal_pkg::MIN_SHIFT];
        mins_mul  = {6'd0, mins_next} * {10'd0, ep2cal_pkg::SIXTY};
        sec5_next = 6'(tod4_reg - mins_mul);
    end

    always_comb begin
        prodh_next = {12'd0, mins_reg} * {11'd0, ep2cal_pkg::HOUR_RECIP};
    end

    always_comb begin
        hour7_next   = prodh_reg[21:ep2cal_pkg::HOUR_SHIFT];
        hour_mul     = {6'd0, hour7_next} * {4'd0, ep2cal_pkg::SIXTY};
        minute7_next = 6'(mins6_reg - hour_mul);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg      <= s_epoch_seconds;
            s2_reg      <= s1_reg;
            prod1_reg   <= prod1_next;
            days_reg    <= days_next;
            tod_reg     <= tod_next;
            tod4_reg    <= tod_reg;
            prods_reg   <= prods_next;
            mins_reg    <= mins_next;
            sec5_reg    <= sec5_next;
            prodh_reg   <= prodh_next;
            mins6_reg   <= mins_reg;
            sec6_reg    <= sec5_reg;
            hour7_reg   <= hour7_next;
            minute7_reg <= minute7_next;
            sec7_reg    <= sec6_reg;
            hour_reg    <= hour7_reg;
            minute_reg  <= minute7_reg;
            second_reg  <= sec7_reg;
        end
    end

    ep2cal_date u_date (
        .aclk            (aclk),
        .en              (adv),
        .days            (days_reg),
        .full_year       (m_full_year),
        .year_in_century (m_year_in_century),
        .month           (m_month),
        .day             (m_day)
    );

    assign m_hour   = hour_reg;
    assign m_minute = minute_reg;
    assign m_second = second_reg;

endmodule

`default_nettype wire

[src/ep2cal_date.sv]
// Five-stage datapath from a day count since 1970 to year, month and day.
`timescale 1ns / 1ps
`default_nettype none

module ep2cal_date (
    input  wire logic                             aclk,
    input  wire logic                             en,
    input  wire logic [ep2cal_pkg::DAYS_W-1:0]    days,
    output logic      [ep2cal_pkg::YEAR_W-1:0]    full_year,
    output logic      [6:0]                       year_in_century,
    output logic      [3:0]                       month,
    output logic      [4:0]                       day
);

    logic [15:0] z_reg, z_next;
    logic [32:0] prodc_reg, prodc_next;

    logic [5:0]  cyc_reg, cyc_next;
    logic [10:0] doc_reg, doc_next;
    logic [15:0] cyc_days;

    logic [22:0] prody_reg, prody_next;
    logic [10:0] doc6_reg;
    logic [5:0]  cyc6_reg;
    logic [10:0] doc_adj;

    logic [8:0]  doy_reg, doy_next;
    logic [11:0] ymarch_reg, ymarch_next;
    logic [1:0]  yoc;
    logic [10:0] yoc_days;

    logic [3:0]  mp;
    logic [8:0]  day_off;
    logic [11:0] year_full;
    logic [11:0] year_yic;

    logic [11:0] year_reg, year_next;
    logic [6:0]  yic_reg, yic_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;

    // Cycles of four March-based years from 1968-03-01; 2100 has no leap day.
    always_comb begin
        z_next = days + ep2cal_pkg::EPOCH_OFFSET
                 + ((days >= ep2cal_pkg::SKIP_LEAP_DAY) ? 16'd1 : 16'd0);
        prodc_next = {17'd0, z_next} * {16'd0, ep2cal_pkg::CYCLE_RECIP};
    end

    always_comb begin
        cyc_next = prodc_reg[32:ep2cal_pkg::CYCLE_SHIFT];
        cyc_days = {10'd0, cyc_next} * {5'd0, ep2cal_pkg::CYCLE_DAYS};
        doc_next = 11'(z_reg - cyc_days);
    end

    always_comb begin
        doc_adj = doc_reg - ((doc_reg == ep2cal_pkg::CYCLE_LAST) ? 11'd1 : 11'd0);
        prody_next = {12'd0, doc_adj} * {11'd0, ep2cal_pkg::YEAR_RECIP};
    end

    always_comb begin
        yoc = prody_reg[21:ep2cal_pkg::YEAR_SHIFT];
        yoc_days = {9'd0, yoc} * {2'd0, ep2cal_pkg::YEAR_DAYS};
        doy_next = 9'(doc6_reg - yoc_days);
        ymarch_next = ep2cal_pkg::BASE_YEAR + {4'd0, cyc6_reg, 2'b00} + {10'd0, yoc};
    end

    always_comb begin
        mp = 4'd0;
        for (int k = 1; k < 12; k++) begin
            if (doy_reg >= ep2cal_pkg::month_start(4'(k))) begin
                mp = mp + 4'd1;
            end
        end
        day_off = doy_reg - ep2cal_pkg::month_start(mp) + 9'd1;
        day_next = day_off[4:0];
        if (mp < ep2cal_pkg::MARCH_JAN) begin
            month_next = mp + 4'd3;
            year_full  = ymarch_reg;
        end else begin
            month_next = mp - 4'd9;
            year_full  = ymarch_reg + 12'd1;
        end
        year_next = year_full;
        if (year_full < 12'd2000) begin
            year_yic = year_full - 12'd1900;
        end else if (year_full < 12'd2100) begin
            year_yic = year_full - 12'd2000;
        end else begin
            year_yic = year_full - 12'd2100;
        end
        yic_next = year_yic[6:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z_reg      <= z_next;
            prodc_reg  <= prodc_next;
            cyc_reg    <= cyc_next;
            doc_reg    <= doc_next;
            prody_reg  <= prody_next;
            doc6_reg   <= doc_reg;
            cyc6_reg   <= cyc_reg;
            doy_reg    <= doy_next;
            ymarch_reg <= ymarch_next;
            year_reg   <= year_next;
            yic_reg    <= yic_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
        end
    end

    assign full_year       = year_reg;
    assign year_in_century = yic_reg;
    assign month           = month_reg;
    assign day             = day_reg;

endmodule

`default_nettype wire

[src/ep2cal_checker.sv]
// Port-level checker for the seconds-to-calendar converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "epoch_seconds_to_calendar_defines.svh"

module ep2cal_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [11:0] m_full_year,
    input wire logic [6:0]  m_year_in_century,
    input wire logic [3:0]  m_month,
    input wire logic [4:0]  m_day,
    input wire logic [4:0]  m_hour,
    input wire logic [5:0]  m_minute,
    input wire logic [5:0]  m_second
);

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_full_year) && $stable(m_month) && $stable(m_day) && $stable(m_second))
    `ASSERT_IMPLY(a_ready_when_drained, aclk, aresetn, m_ready || !m_valid, s_ready)
    `ASSERT_IMPLY(a_date_range, aclk, aresetn, m_valid, m_full_year >= 12'd1970 && m_full_year <= 12'd2106 && m_month >= 4'd1 && m_month <= 4'd12 && m_day >= 5'd1 && m_day <= 5'd31 && m_year_in_century <= 7'd99)
    `ASSERT_IMPLY(a_time_range, aclk, aresetn, m_valid, m_hour <= 5'd23 && m_minute <= 6'd59 && m_second <= 6'd59)

endmodule

bind epoch_seconds_to_calendar ep2cal_checker u_ep2cal_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_full_year       (m_full_year),
    .m_year_in_century (m_year_in_century),
    .m_month           (m_month),
    .m_day             (m_day),
    .m_hour            (m_hour),
    .m_minute          (m_minute),
    .m_second          (m_second)
);

`default_nettype wire

[verif/epoch_seconds_to_calendar_tb.sv]
// Testbench of the seconds-to-calendar converter: directed, random and backpressure checks.
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_tb;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          HOLD_OFF_LEN   = 300;
    localparam int          DRAIN_CYCLES   = 20;
    localparam int unsigned SECS_PER_DAY   = 86400;
    localparam int unsigned SECS_PER_HOUR  = 3600;
    localparam int unsigned SECS_PER_MIN   = 60;
    localparam int unsigned FIRST_YEAR     = 1970;
    localparam int unsigned LAST_DAY_INDEX = 49710;
    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic [ep2cal_pkg::YEAR_W-1:0] full_year;
        logic [6:0]                    year_in_century;
        logic [3:0]                    month;
        logic [4:0]                    day;
        logic [4:0]                    hour;
        logic [5:0]                    minute;
        logic [5:0]                    second;
    } calendar_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    logic [ep2cal_pkg::EPOCH_W-1:0] s_epoch_seconds;
    logic                           m_valid;
    logic                           m_ready;
    logic [ep2cal_pkg::YEAR_W-1:0]  m_full_year;
    logic [6:0]                     m_year_in_century;
    logic [3:0]                     m_month;
    logic [4:0]                     m_day;
    logic [4:0]                     m_hour;
    logic [5:0]                     m_minute;
    logic [5:0]                     m_second;

    calendar_t expected_dates [$];
    int        error_count     = 0;
    int        idle_cycles     = 0;
    bit        gaps_enabled    = 1'b1;
    int        hold_off_cycles = 0;
    bit        results_held    = 1'b0;

    epoch_seconds_to_calendar u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_epoch_seconds   (s_epoch_seconds),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_full_year       (m_full_year),
        .m_year_in_century (m_year_in_century),
        .m_month           (m_month),
        .m_day             (m_day),
        .m_hour            (m_hour),
        .m_minute          (m_minute),
        .m_second          (m_second)
    );

    initial aclk = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic bit leap_year(input int unsigned yr);
        return ((yr % 4) == 0) && (((yr % 100) != 0) || ((yr % 400) == 0));
    endfunction

    function automatic calendar_t compute_calendar(input logic [ep2cal_pkg::EPOCH_W-1:0] secs);
        calendar_t   cal;
        int unsigned days;
        int unsigned tod;
        int unsigned yr;
        int unsigned mon;
        int unsigned mlen;
        days = secs / SECS_PER_DAY;
        tod  = secs % SECS_PER_DAY;
        yr   = FIRST_YEAR;
        while (days >= (leap_year(yr) ? 366 : 365)) begin
            days = days - (leap_year(yr) ? 366 : 365);
            yr++;
        end
        mon = 0;
        while (mon < 11) begin
            mlen = MONTH_DAYS[mon] + ((mon == 1 && leap_year(yr)) ? 1 : 0);
            if (days < mlen) break;
            days = days - mlen;
            mon++;
        end
        cal.full_year       = yr[ep2cal_pkg::YEAR_W-1:0];
        cal.year_in_century = 7'(yr % 100);
        cal.month           = 4'(mon + 1);
        cal.day             = 5'(days + 1);
        cal.hour            = 5'(tod / SECS_PER_HOUR);
        cal.minute          = 6'((tod % SECS_PER_HOUR) / SECS_PER_MIN);
        cal.second          = 6'(tod % SECS_PER_MIN);
        return cal;
    endfunction

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (!gaps_enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_timestamp(input logic [ep2cal_pkg::EPOCH_W-1:0] secs);
        int gap;
        s_valid         <= 1'b1;
        s_epoch_seconds <= secs;
        do @(posedge aclk); while (!s_ready);
        expected_dates.push_back(compute_calendar(secs));
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Result side: ready in random runs, random stalls, and one long hold-off on request.
    initial begin
        int n;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_cycles > 0) begin
                n               = hold_off_cycles;
                hold_off_cycles = 0;
                results_held    = 1'b1;
                m_ready        <= 1'b0;
                repeat (n) @(posedge aclk);
                results_held    = 1'b0;
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
                n = pick_gap();
                if (n > 0) begin
                    m_ready <= 1'b0;
                    repeat (n) @(posedge aclk);
                end
            end
        end
    end

    always @(posedge aclk) begin
        calendar_t exp_cal;
        if (aresetn && m_valid && m_ready) begin
            if (expected_dates.size() == 0) begin
                $error("result accepted with no request pending");
                error_count++;
            end else begin
                exp_cal = expected_dates.pop_front();
                if (m_full_year !== exp_cal.full_year) begin
                    $error("full_year mismatch: expected %0d, actual %0d",
                           exp_cal.full_year, m_full_year);
                    error_count++;
                end
                if (m_year_in_century !== exp_cal.year_in_century) begin
                    $error("year_in_century mismatch: expected %0d, actual %0d",
                           exp_cal.year_in_century, m_year_in_century);
                    error_count++;
                end
                if (m_month !== exp_cal.month) begin
                    $error("month mismatch: expected %0d, actual %0d", exp_cal.month, m_month);
                    error_count++;
                end
                if (m_day !== exp_cal.day) begin
                    $error("day mismatch: expected %0d, actual %0d", exp_cal.day, m_day);
                    error_count++;
                end
                if (m_hour !== exp_cal.hour) begin
                    $error("hour mismatch: expected %0d, actual %0d", exp_cal.hour, m_hour);
                    error_count++;
                end
                if (m_minute !== exp_cal.minute) begin
                    $error("minute mismatch: expected %0d, actual %0d",
                           exp_cal.minute, m_minute);
                    error_count++;
                end
                if (m_second !== exp_cal.second) begin
                    $error("second mismatch: expected %0d, actual %0d",
                           exp_cal.second, m_second);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Field extremes plus the leap-day, century and end-of-range boundaries.
    task automatic test_directed();
        send_timestamp(32'd0);
        send_timestamp(32'd1);
        send_timestamp(32'd59);
        send_timestamp(32'd60);
        send_timestamp(32'd3599);
        send_timestamp(32'd3600);
        send_timestamp(32'd86399);
        send_timestamp(32'd86400);
        send_timestamp(32'd31535999);
        send_timestamp(32'd68169600);
        send_timestamp(32'd68255999);
        send_timestamp(32'd68256000);
        send_timestamp(32'd946684799);
        send_timestamp(32'd951782400);
        send_timestamp(32'd951868800);
        send_timestamp(32'd978307199);
        send_timestamp(32'd978307200);
        send_timestamp(32'h7FFF_FFFF);
        send_timestamp(32'h8000_0000);
        send_timestamp(32'd4107542399);
        send_timestamp(32'd4107542400);
        send_timestamp(32'hFFFF_FFFE);
        send_timestamp(32'hFFFF_FFFF);
    endtask

    // Uniform timestamps mixed with ones placed at the start or end of a day.
    task automatic test_random(input int count);
        logic [63:0] wide;
        int          pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 2);
            if (pick == 0) begin
                send_timestamp($urandom());
            end else begin
                wide = 64'($urandom_range(0, LAST_DAY_INDEX)) * SECS_PER_DAY;
                wide = wide + ((pick == 1) ? 0 : SECS_PER_DAY - 1 - $urandom_range(0, 1));
                if (wide > 64'hFFFF_FFFF) wide = 64'hFFFF_FFFF;
                send_timestamp(wide[ep2cal_pkg::EPOCH_W-1:0]);
            end
        end
    endtask

    task automatic test_back_to_back(input int count);
        gaps_enabled = 1'b0;
        for (int i = 0; i < count; i++) send_timestamp($urandom());
        gaps_enabled = 1'b1;
    endtask

    // The result side stops for a long time while requests keep coming.
    task automatic test_backpressure(input int count);
        gaps_enabled    = 1'b0;
        s_valid        <= 1'b0;
        hold_off_cycles = HOLD_OFF_LEN;
        while (!results_held) @(posedge aclk);
        for (int i = 0; i < count; i++) send_timestamp($urandom());
        gaps_enabled = 1'b1;
    endtask

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_epoch_seconds = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(800);
        test_back_to_back(100);
        test_backpressure(40);
        test_random(60);

        s_valid <= 1'b0;
        while (expected_dates.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_dates.size() != 0) error_count++;

        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
